>>> rtl/positional_array_list_macros.svh
// Assertion helpers; the using module must have aclk and aresetn.
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

`define PAL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("positional_array_list: assertion failed");

`define PAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("positional_array_list: assertion failed");

`endif

>>> rtl/pal_pkg.sv
package pal_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int IDX_W     = 8;
    localparam int CNT_W     = 5;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 4;
    localparam int CMD_W     = 3;
    localparam int IN_W      = 40;
    localparam int OUT_W     = 48;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND      = 3'd0,
        CMD_INSERT_AT   = 3'd1,
        CMD_REMOVE_LAST = 3'd2,
        CMD_REMOVE_AT   = 3'd3,
        CMD_READ_AT     = 3'd4,
        CMD_FIND_MAX    = 3'd5
    } cmd_e;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic              shift_up;
        logic              shift_down;
        idx_t              pos;
        logic [DATA_W-1:0] din;
    } cell_cmd_t;

    typedef struct packed {
        logic find_max;
        idx_t target;
        idx_t count;
    } scan_ctl_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        idx_t              index;
    } scan_t;

    function automatic logic [OUT_W-1:0] pack_result(
        input logic              ok,
        input logic [DATA_W-1:0] data,
        input logic [POS_W-1:0]  max_idx,
        input logic [CNT_W-1:0]  cnt,
        input logic [CNT_W-1:0]  cap
    );
        logic [OUT_W-1:0] r;
        r = '0;
        r[0]     = ok;
        r[32:1]  = data;
        r[36:33] = max_idx;
        r[41:37] = cnt;
        r[42]    = (cnt == '0);
        r[43]    = (cnt >= cap);
        return r;
    endfunction

endpackage

>>> rtl/pal_cell.sv
module pal_cell
    import pal_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic              aclk,
    input  cell_cmd_t         cmd,
    input  scan_ctl_t         sctl,
    input  logic [DATA_W-1:0] left_entry,
    input  logic [DATA_W-1:0] right_entry,
    input  scan_t             scan_in,
    output logic [DATA_W-1:0] entry_out,
    output scan_t             scan_out
);

    localparam idx_t MY_IDX = IDX_W'(INDEX);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    scan_t             scan_reg;
    scan_t             scan_next;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.shift_up) begin
            if (MY_IDX == cmd.pos) begin
                entry_next = cmd.din;
            end else if (MY_IDX > cmd.pos) begin
                entry_next = left_entry;
            end
        end else if (cmd.shift_down && (MY_IDX >= cmd.pos)) begin
            entry_next = right_entry;
        end
    end

    always_comb begin
        scan_next = scan_in;
        if (sctl.find_max) begin
            if (MY_IDX == '0) begin
                scan_next.value = entry_reg;
                scan_next.index = MY_IDX;
            end else if ((MY_IDX < sctl.count) &&
                         ($signed(entry_reg) > $signed(scan_in.value))) begin
                scan_next.value = entry_reg;
                scan_next.index = MY_IDX;
            end
        end else if (MY_IDX == sctl.target) begin
            scan_next.value = entry_reg;
            scan_next.index = MY_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        scan_reg  <= scan_next;
    end

    assign entry_out = entry_reg;
    assign scan_out  = scan_reg;

endmodule

>>> rtl/pal_ctrl.sv
`include "positional_array_list_macros.svh"

module pal_ctrl
    import pal_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    input  scan_t            scan_last,
    output cell_cmd_t        cmd,
    output scan_ctl_t        sctl
);

    localparam int SCW = $clog2(DEPTH + 1);
    localparam logic [SCW-1:0] SCAN_LAST = SCW'(DEPTH);

    state_t           state_reg, state_next;
    logic [SCW-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] capacity_reg;
    cmd_e             op_reg, op_next;
    scan_ctl_t        sctl_reg, sctl_next;
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_data_reg, m_data_next;

    logic [CMD_W-1:0]  cmd_in;
    logic [POS_W-1:0]  pos_in;
    logic [DATA_W-1:0] din_in;
    logic [CNT_W-1:0]  cap_eff;
    logic              m_free;
    logic              res_ok;
    logic              scan_go;
    logic              can_add;

    assign cmd_in = s_tdata[2:0];
    assign pos_in = s_tdata[6:3];
    assign din_in = s_tdata[38:7];
    assign m_free = !m_valid_reg || m_tready;

    always_comb begin
        if (capacity_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (32'(capacity_reg) > 32'(DEPTH)) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = capacity_reg;
        end
    end

    assign can_add = (count_reg < cap_eff);

    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        sctl_next     = sctl_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        cmd           = '0;
        cmd.din       = din_in;
        s_tready      = 1'b0;
        res_ok        = 1'b0;
        scan_go       = 1'b0;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = m_free;
                if (s_tvalid && m_free) begin
                    sctl_next.count = IDX_W'(count_reg);
                    unique case (cmd_in)
                        CMD_APPEND: begin
                            if (can_add) begin
                                cmd.shift_up = 1'b1;
                                cmd.pos      = IDX_W'(count_reg);
                                count_next   = count_reg + CNT_W'(1);
                                res_ok       = 1'b1;
                            end
                        end
                        CMD_INSERT_AT: begin
                            if (can_add && (CNT_W'(pos_in) <= count_reg)) begin
                                cmd.shift_up = 1'b1;
                                cmd.pos      = IDX_W'(pos_in);
                                count_next   = count_reg + CNT_W'(1);
                                res_ok       = 1'b1;
                            end
                        end
                        CMD_REMOVE_LAST: begin
                            if (count_reg != '0) begin
                                scan_go            = 1'b1;
                                sctl_next.find_max = 1'b0;
                                sctl_next.target   = IDX_W'(count_reg - CNT_W'(1));
                            end
                        end
                        CMD_REMOVE_AT, CMD_READ_AT: begin
                            if (CNT_W'(pos_in) < count_reg) begin
                                scan_go            = 1'b1;
                                sctl_next.find_max = 1'b0;
                                sctl_next.target   = IDX_W'(pos_in);
                            end
                        end
                        CMD_FIND_MAX: begin
                            if (count_reg != '0) begin
                                scan_go            = 1'b1;
                                sctl_next.find_max = 1'b1;
                                sctl_next.target   = '0;
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (scan_go) begin
                        state_next    = ST_SCAN;
                        scan_cnt_next = '0;
                        op_next       = cmd_e'(cmd_in);
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next  = pack_result(res_ok, '0, '0, count_next, cap_eff);
                    end
                end
            end
            ST_SCAN: begin
                if (scan_cnt_reg != SCAN_LAST) begin
                    scan_cnt_next = scan_cnt_reg + SCW'(1);
                end else if (m_free) begin
                    state_next = ST_IDLE;
                    if (op_reg == CMD_REMOVE_AT) begin
                        cmd.shift_down = 1'b1;
                        cmd.pos        = sctl_reg.target;
                    end
                    if ((op_reg == CMD_REMOVE_AT) || (op_reg == CMD_REMOVE_LAST)) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = pack_result(1'b1, scan_last.value,
                        (op_reg == CMD_FIND_MAX) ? scan_last.index[POS_W-1:0] : '0,
                        count_next, cap_eff);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            count_reg    <= '0;
            capacity_reg <= CAP_RESET;
            op_reg       <= CMD_APPEND;
            sctl_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            count_reg    <= count_next;
            op_reg       <= op_next;
            sctl_reg     <= sctl_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign sctl     = sctl_reg;

    `PAL_ASSERT_SAME(a_count_bound, 1'b1, 32'(count_reg) <= DEPTH)
    `PAL_ASSERT_SAME(a_ready_idle, state_reg != ST_IDLE, !s_tready)
    `PAL_ASSERT_SAME(a_scan_cnt_bound, 1'b1, scan_cnt_reg <= SCAN_LAST)
    `PAL_ASSERT_NEXT(a_quick_result, s_tvalid && s_tready && (state_next == ST_IDLE), m_valid_reg)

endmodule

>>> rtl/positional_array_list.sv
// Channel | Handshake          | Beat contents (lowest bit first)
// s_      | s_tvalid, s_tready | command[2:0], position[6:3], data_in[38:7]
// m_      | m_tvalid, m_tready | ok, data_out, max_index, count, is_empty, is_full
// cfg_    | cfg_we             | capacity[4:0]
// Append, insert and every rejected command give their result in the cycle after the
// beat is taken, so such commands run at one per cycle while the output is free.
// Remove, read and find-max send a scan through the chain of DEPTH cells, one cell
// per cycle; the result is sent after the scan has left the last cell, with no beat
// taken meanwhile. Reset clears the count and sets the capacity to 16; entries are not
// cleared. A stalled result holds the block, and no new beat is taken until the
// output register is free.
module positional_array_list
    import pal_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // command[2:0], position[6:3], data_in[38:7], zero fill
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // ok[0], data_out[32:1], max_index[36:33], count[41:37], is_empty[42],
    // is_full[43], zero fill
    output logic [OUT_W-1:0] m_tdata
);

    cell_cmd_t         cmd;
    scan_ctl_t         sctl;
    logic [DATA_W-1:0] entry_w [DEPTH];
    scan_t             scan_w  [DEPTH];

    pal_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .scan_last (scan_w[DEPTH-1]),
        .cmd       (cmd),
        .sctl      (sctl)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;
        scan_t             scan_in_w;

        if (g == 0) begin : g_first
            assign left_w    = '0;
            assign scan_in_w = '0;
        end else begin : g_inner
            assign left_w    = entry_w[g-1];
            assign scan_in_w = scan_w[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_w = entry_w[g];
        end else begin : g_body
            assign right_w = entry_w[g+1];
        end

        pal_cell #(
            .INDEX (g)
        ) u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .sctl        (sctl),
            .left_entry  (left_w),
            .right_entry (right_w),
            .scan_in     (scan_in_w),
            .entry_out   (entry_w[g]),
            .scan_out    (scan_w[g])
        );
    end

endmodule

>>> test/positional_array_list_checker.sv
`timescale 1ns / 100ps

module positional_array_list_checker
    import pal_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    output int               mismatches,
    output int               outstanding
);

    typedef struct {
        logic              ok;
        logic [DATA_W-1:0] data_out;
        logic [POS_W-1:0]  max_index;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
        logic              is_full;
    } list_result_t;

    logic [DATA_W-1:0] list_vals [DEPTH_DEF];
    logic [CNT_W-1:0]  list_len;
    logic [CNT_W-1:0]  capacity;
    list_result_t      expected_results [$];

    function automatic logic [CNT_W-1:0] usable_capacity();
        if (capacity == '0) begin
            return CNT_W'(1);
        end
        if (capacity > DEPTH_DEF) begin
            return CNT_W'(DEPTH_DEF);
        end
        return capacity;
    endfunction

    function automatic list_result_t apply_command(logic [CMD_W-1:0] cmd,
                                                   logic [POS_W-1:0] pos,
                                                   logic [DATA_W-1:0] din);
        list_result_t             r;
        logic [CNT_W-1:0]         cap;
        logic signed [DATA_W-1:0] best;
        r = '{default: '0};
        cap = usable_capacity();
        case (cmd)
            CMD_APPEND: begin
                if (list_len < cap) begin
                    list_vals[POS_W'(list_len)] = din;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            CMD_INSERT_AT: begin
                if (list_len < cap && pos <= list_len) begin
                    for (int i = list_len; i > pos; i--) begin
                        list_vals[i] = list_vals[i-1];
                    end
                    list_vals[pos] = din;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            CMD_REMOVE_LAST: begin
                if (list_len != '0) begin
                    list_len--;
                    r.data_out = list_vals[POS_W'(list_len)];
                    r.ok = 1'b1;
                end
            end
            CMD_REMOVE_AT: begin
                if (pos < list_len) begin
                    r.data_out = list_vals[pos];
                    for (int i = pos; i + 1 < list_len; i++) begin
                        list_vals[i] = list_vals[i+1];
                    end
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            CMD_READ_AT: begin
                if (pos < list_len) begin
                    r.data_out = list_vals[pos];
                    r.ok = 1'b1;
                end
            end
            CMD_FIND_MAX: begin
                if (list_len != '0) begin
                    best = list_vals[0];
                    for (int i = 1; i < list_len; i++) begin
                        if ($signed(list_vals[i]) > best) begin
                            best = list_vals[i];
                            r.max_index = POS_W'(i);
                        end
                    end
                    r.data_out = best;
                    r.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.count    = list_len;
        r.is_empty = (list_len == '0);
        r.is_full  = (list_len >= cap);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        if (mismatches < 40) begin
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        end
        mismatches++;
    endtask

    // Both channels are sampled before the drivers' updates at the same edge land.
    always @(posedge aclk) begin
        list_result_t want;
        if (!aresetn) begin
            list_len = '0;
            capacity = CAP_RESET;
            expected_results.delete();
            mismatches = 0;
        end else begin
            if (cfg_we) begin
                capacity = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_command(s_tdata[2:0], s_tdata[6:3],
                                                         s_tdata[38:7]));
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected", m_tdata[32:1], '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[0] !== want.ok) begin
                        report_mismatch("ok", DATA_W'(m_tdata[0]), DATA_W'(want.ok));
                    end
                    if (m_tdata[32:1] !== want.data_out) begin
                        report_mismatch("data_out", m_tdata[32:1], want.data_out);
                    end
                    if (m_tdata[36:33] !== want.max_index) begin
                        report_mismatch("max_index", DATA_W'(m_tdata[36:33]),
                                        DATA_W'(want.max_index));
                    end
                    if (m_tdata[41:37] !== want.count) begin
                        report_mismatch("count", DATA_W'(m_tdata[41:37]), DATA_W'(want.count));
                    end
                    if (m_tdata[42] !== want.is_empty) begin
                        report_mismatch("is_empty", DATA_W'(m_tdata[42]),
                                        DATA_W'(want.is_empty));
                    end
                    if (m_tdata[43] !== want.is_full) begin
                        report_mismatch("is_full", DATA_W'(m_tdata[43]), DATA_W'(want.is_full));
                    end
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

>>> test/positional_array_list_tb.sv
`timescale 1ns / 100ps

module positional_array_list_tb;
    import pal_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int SCAN_CYCLES = DEPTH_DEF + 1;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_LIMIT = 2000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 103;

    localparam logic [CMD_W-1:0]  CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0]  CMD_SPARE_7 = 3'd7;
    localparam logic [DATA_W-1:0] VAL_MIN     = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_MAX     = 32'h7fff_ffff;

    localparam logic [CNT_W-1:0] PHASE_CAPACITY [PHASES] =
        '{5'd16, 5'd2, 5'd0, 5'd31, 5'd5, 5'd1, 5'd20, 5'd16, 5'd9, 5'd16};
    localparam int PHASE_GROWTH [PHASES] = '{60, 30, 45, 70, 45, 50, 75, 40, 35, 20};

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    int mismatches;
    int outstanding;
    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;

    positional_array_list i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    positional_array_list_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    initial begin
        #(CLK_PERIOD * 600000);
        $display("[positional_array_list] ERROR");
        $finish;
    end

    // The long hold-off keeps the output blocked while the sender keeps offering beats.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= 18);
            end
        end
    end

    task automatic idle_gap();
        while (!no_idle && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                logic [DATA_W-1:0] din);
        idle_gap();
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, din, pos, cmd};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2, 3: return DATA_W'($urandom_range(4)) - DATA_W'(2);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(1) == 0) begin
            return POS_W'($urandom_range(15));
        end
        return POS_W'($urandom_range(4));
    endfunction

    task automatic run_phase(int items, int grow_pct);
        int               r;
        logic [CMD_W-1:0] cmd;
        repeat (items) begin
            r = $urandom_range(99);
            if (r < grow_pct) begin
                cmd = $urandom_range(1) ? CMD_APPEND : CMD_INSERT_AT;
            end else if (r < 95) begin
                case ($urandom_range(3))
                    0: cmd = CMD_REMOVE_LAST;
                    1: cmd = CMD_REMOVE_AT;
                    2: cmd = CMD_READ_AT;
                    default: cmd = CMD_FIND_MAX;
                endcase
            end else begin
                cmd = $urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7;
            end
            send_command(cmd, pick_position(), pick_value());
        end
    endtask

    initial begin
        int drain_cycles;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_command(CMD_FIND_MAX, 4'd0, pick_value());
        send_command(CMD_REMOVE_LAST, 4'd0, pick_value());
        send_command(CMD_REMOVE_AT, 4'd0, pick_value());
        send_command(CMD_READ_AT, 4'd0, pick_value());
        send_command(CMD_INSERT_AT, 4'd1, pick_value());
        send_command(CMD_APPEND, 4'd0, VAL_MIN);
        send_command(CMD_APPEND, 4'd15, VAL_MAX);
        send_command(CMD_INSERT_AT, 4'd0, '1);
        send_command(CMD_INSERT_AT, 4'd3, '0);
        send_command(CMD_FIND_MAX, 4'd0, pick_value());
        send_command(CMD_READ_AT, 4'd15, pick_value());
        send_command(CMD_READ_AT, 4'd3, pick_value());
        send_command(CMD_REMOVE_AT, 4'd4, pick_value());
        send_command(CMD_REMOVE_AT, 4'd1, pick_value());
        send_command(CMD_REMOVE_AT, 4'd1, pick_value());
        send_command(CMD_REMOVE_LAST, 4'd0, pick_value());
        send_command(CMD_INSERT_AT, 4'd0, -DATA_W'(3));
        send_command(CMD_APPEND, 4'd0, '1);
        send_command(CMD_FIND_MAX, 4'd0, pick_value());
        send_command(CMD_SPARE_6, 4'd15, '1);
        send_command(CMD_SPARE_7, 4'd0, '0);
        send_command(CMD_REMOVE_AT, 4'd0, pick_value());

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(PHASE_CAPACITY[p]);
            no_idle = (p == 3);
            if (p == 7) begin
                hold_req = 1'b1;
            end
            run_phase(PHASE_ITEMS, PHASE_GROWTH[p]);
        end
        no_idle = 1'b0;

        s_tvalid <= 1'b0;
        drain_cycles = 0;
        do begin
            @(posedge aclk);
            drain_cycles++;
        end while (outstanding != 0 && drain_cycles < DRAIN_LIMIT);
        repeat (SCAN_CYCLES + 4) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("[positional_array_list] OK");
        end else begin
            $display("[positional_array_list] ERROR");
        end
        $finish;
    end

endmodule
